@@ design/phong_specular_evaluate_assert.svh @@
// ----------------------------------------------------------------------------
// Phong specular evaluate - assertion macros
// Shared concurrent assertion forms. Sampled on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PHONG_SPECULAR_EVALUATE_ASSERT_SVH
`define PHONG_SPECULAR_EVALUATE_ASSERT_SVH

// same-cycle implication
`define PHS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("phong specular check failed");

// implication with a fixed delay in cycles
`define PHS_ASSERT_DLY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error("phong specular check failed");

`endif

@@ design/phs_pkg.sv @@
// ----------------------------------------------------------------------------
// phs_pkg
// Widths, interface structs and constant log2/exp2 tables of the Phong
// specular evaluator.
// ----------------------------------------------------------------------------
package phs_pkg;

    localparam int CW        = 16;              // vector component width
    localparam int LTB       = 8;               // log/exp table index bits
    localparam int FB        = CW - 2;          // component fraction bits
    localparam int HALF      = 1 << (FB - 1);   // rounding constant

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAD_W     = 16;
    localparam int SHIN_FRAC = 8;               // shininess is Q8.8
    localparam int LOG_FRAC  = 16;              // log2 fraction bits

    localparam int PROD_W    = 2 * CW;          // n*wi
    localparam int DOT_W     = 2 * CW + 2;      // n.wi
    localparam int ND_W      = DOT_W - FB;      // rounded n.wi
    localparam int P2_W      = CW + ND_W;       // n*nd
    localparam int R_W       = CW + 6;          // reflected component
    localparam int RW_W      = R_W + CW;        // r*wo
    localparam int D_W       = RW_W + 2;        // r.wo
    localparam int P_W       = $clog2(D_W);     // leading-one position
    localparam int LG_W      = LOG_FRAC + P_W + 2;
    localparam int PR_W      = LG_W + CFG_W + 1;
    localparam int Q_W       = PR_W - SHIN_FRAC - LOG_FRAC;

    localparam int PTAB_W    = 31;              // Q1.30 power mantissa
    localparam int KC_W      = 2 * CFG_W;       // ks*color
    localparam int M_W       = KC_W + PTAB_W;
    localparam int SH_BITS   = $clog2(M_W);
    localparam int SCALE_SH  = 2 * CFG_W + PTAB_W - 1 - RAD_W;
    localparam int LOG_N     = 1 << LTB;

    localparam int PIPE_LAT  = 12;              // accept to result strobe
    localparam int SCALE_LAT = 2;               // power stage to result

    localparam logic [RAD_W-1:0] RAD_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN  = 3'd0,
        CFG_RED   = 3'd1,
        CFG_GREEN = 3'd2,
        CFG_BLUE  = 3'd3,
        CFG_SHINE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                  valid;
        logic signed [D_W-1:0] d;
    } t_dot;

    typedef struct packed {
        logic                  valid;
        logic                  pos;
        logic signed [Q_W-1:0] q;
        logic [PTAB_W-1:0]     ptab;
    } t_pow;

    typedef logic [LOG_FRAC-1:0] t_log_tab [0:LOG_N-1];
    typedef logic [PTAB_W-1:0]   t_exp_tab [0:LOG_N-1];

    // log2(1 + i/2^LTB) in Q0.16 by repeated squaring of a Q1.30 mantissa
    function automatic logic [LOG_FRAC-1:0] log_entry(input int unsigned i);
        logic [63:0] m;
        logic [63:0] acc;
        m   = (64'd1 << 30) + (64'(i) << (30 - LTB));
        acc = '0;
        for (int k = 0; k < LOG_FRAC; k++) begin
            m   = (m * m) >> 30;
            acc = acc << 1;
            if (m >= (64'd1 << 31)) begin
                acc[0] = 1'b1;
                m      = m >> 1;
            end
        end
        return acc[LOG_FRAC-1:0];
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = n;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab tab;
        for (int i = 0; i < LOG_N; i++) begin
            tab[i] = log_entry(i);
        end
        return tab;
    endfunction

    // 2^(j/2^LTB) in Q1.30: product of 2^(2^-k) over the set bits of j
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] c [1:LTB];
        logic [63:0] acc;
        c[1] = isqrt64(64'd1 << 61);
        for (int k = 2; k <= LTB; k++) begin
            c[k] = isqrt64(c[k-1] << 30);
        end
        for (int j = 0; j < LOG_N; j++) begin
            acc = 64'd1 << 30;
            for (int k = 1; k <= LTB; k++) begin
                if (((j >> (LTB - k)) & 1) == 1) begin
                    acc = (acc * c[k]) >> 30;
                end
            end
            tab[j] = acc[PTAB_W-1:0];
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();
    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

@@ design/phs_dot.sv @@
// ----------------------------------------------------------------------------
// phs_dot
// Six-stage reflection and dot product: r = 2(n.wi)n - wi, d = r.wo.
// ----------------------------------------------------------------------------
module phs_dot
    import phs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_n  [3],
    input  logic signed [CW-1:0] i_wi [3],
    input  logic signed [CW-1:0] i_wo [3],
    output t_dot                 o_dot
);

    logic [5:0] r_vld;

    logic signed [PROD_W-1:0] r_a_nw [3];
    logic signed [CW-1:0]     r_a_n  [3];
    logic signed [CW-1:0]     r_a_wi [3];
    logic signed [CW-1:0]     r_a_wo [3];

    logic signed [ND_W-1:0]   r_b_nd;
    logic signed [CW-1:0]     r_b_n  [3];
    logic signed [CW-1:0]     r_b_wi [3];
    logic signed [CW-1:0]     r_b_wo [3];

    logic signed [P2_W-1:0]   r_c_p2 [3];
    logic signed [CW-1:0]     r_c_wi [3];
    logic signed [CW-1:0]     r_c_wo [3];

    logic signed [R_W-1:0]    r_d_r  [3];
    logic signed [CW-1:0]     r_d_wo [3];

    logic signed [RW_W-1:0]   r_e_rw [3];
    logic signed [D_W-1:0]    r_f_d;

    logic signed [PROD_W-1:0] n_a_nw [3];
    logic signed [DOT_W-1:0]  dot_sum;
    logic signed [DOT_W-1:0]  dot_rnd;
    logic signed [ND_W-1:0]   n_b_nd;
    logic signed [P2_W-1:0]   n_c_p2 [3];
    logic signed [P2_W+1:0]   dbl    [3];
    logic signed [P2_W+1:0]   dbl_sh [3];
    logic signed [R_W-1:0]    n_d_r  [3];
    logic signed [RW_W-1:0]   n_e_rw [3];
    logic signed [D_W-1:0]    n_f_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_nw[i] = i_n[i] * i_wi[i];
        end

        dot_sum = DOT_W'(r_a_nw[0]) + DOT_W'(r_a_nw[1]) + DOT_W'(r_a_nw[2]);
        dot_rnd = (dot_sum + DOT_W'(HALF)) >>> FB;
        n_b_nd  = ND_W'(dot_rnd);

        for (int i = 0; i < 3; i++) begin
            n_c_p2[i] = r_b_n[i] * r_b_nd;
            dbl[i]    = ((P2_W+2)'(r_c_p2[i]) <<< 1) + (P2_W+2)'(HALF);
            dbl_sh[i] = dbl[i] >>> FB;
            n_d_r[i]  = R_W'(dbl_sh[i]) - R_W'(r_c_wi[i]);
            n_e_rw[i] = r_d_r[i] * r_d_wo[i];
        end

        n_f_d = D_W'(r_e_rw[0]) + D_W'(r_e_rw[1]) + D_W'(r_e_rw[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_nw[i] <= n_a_nw[i];
            r_a_n[i]  <= i_n[i];
            r_a_wi[i] <= i_wi[i];
            r_a_wo[i] <= i_wo[i];
            r_b_n[i]  <= r_a_n[i];
            r_b_wi[i] <= r_a_wi[i];
            r_b_wo[i] <= r_a_wo[i];
            r_c_p2[i] <= n_c_p2[i];
            r_c_wi[i] <= r_b_wi[i];
            r_c_wo[i] <= r_b_wo[i];
            r_d_r[i]  <= n_d_r[i];
            r_d_wo[i] <= r_c_wo[i];
            r_e_rw[i] <= n_e_rw[i];
        end
        r_b_nd <= n_b_nd;
        r_f_d  <= n_f_d;
    end

    assign o_dot.valid = r_vld[5];
    assign o_dot.d     = r_f_d;

endmodule

@@ design/phs_log.sv @@
// ----------------------------------------------------------------------------
// phs_log
// Four-stage power path: leading one, log2 table, times shininess, exp2 table.
// ----------------------------------------------------------------------------
module phs_log
    import phs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dot             i_dot,
    input  logic [CFG_W-1:0] i_shininess,
    output t_pow             o_pow
);

    logic [2:0]               r_vld;
    logic [2:0]               r_pos;
    logic [D_W-2:0]           r_g_ud;
    logic [P_W-1:0]           r_g_p;
    logic signed [LG_W-1:0]   r_h_lg;
    logic signed [PR_W-1:0]   r_i_prod;
    t_pow                     r_pow;

    logic                     n_g_pos;
    logic [P_W-1:0]           n_g_p;
    logic [P_W-1:0]           norm_sh;
    logic [D_W-2:0]           norm;
    logic [LTB-1:0]           idx;
    logic signed [LG_W-17:0]  lg_int;
    logic signed [LG_W-1:0]   n_h_lg;
    logic signed [PR_W-1:0]   n_i_prod;
    t_pow                     n_pow;

    always_comb begin
        // d > 0: sign clear and some magnitude bit set
        n_g_pos = !i_dot.d[D_W-1] && (|i_dot.d[D_W-2:0]);
        n_g_p   = '0;
        for (int i = 0; i < D_W - 1; i++) begin
            if (i_dot.d[i]) begin
                n_g_p = P_W'(i);
            end
        end

        // bring the leading one to the top, table index sits right below it
        norm_sh = P_W'(D_W - 2) - r_g_p;
        norm    = r_g_ud << norm_sh;
        idx     = norm[D_W-3 -: LTB];
        lg_int  = (LG_W-16)'(r_g_p) - (LG_W-16)'(2 * FB);
        n_h_lg  = {lg_int, LOG_TAB[idx]};

        n_i_prod = r_h_lg * $signed({1'b0, i_shininess});

        n_pow.valid = r_vld[2];
        n_pow.pos   = r_pos[2];
        n_pow.q     = r_i_prod[PR_W-1 -: Q_W];
        n_pow.ptab  = EXP_TAB[r_i_prod[SHIN_FRAC+LOG_FRAC-1 -: LTB]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_pow.valid <= 1'b0;
        end else begin
            r_vld       <= {r_vld[1:0], i_dot.valid};
            r_pow.valid <= n_pow.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= {r_pos[1:0], n_g_pos};
        r_g_ud     <= i_dot.d[D_W-2:0];
        r_g_p      <= n_g_p;
        r_h_lg     <= n_h_lg;
        r_i_prod   <= n_i_prod;
        r_pow.pos  <= n_pow.pos;
        r_pow.q    <= n_pow.q;
        r_pow.ptab <= n_pow.ptab;
    end

    assign o_pow = r_pow;

endmodule

@@ design/phs_scale.sv @@
// ----------------------------------------------------------------------------
// phs_scale
// Two-stage channel scaling: ks*c*2^x, then shift by the integer exponent and
// saturate to Q0.16.
// ----------------------------------------------------------------------------
module phs_scale
    import phs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pow             i_pow,
    input  logic [CFG_W-1:0] i_gain,
    input  logic [CFG_W-1:0] i_color [3],
    output logic             o_valid,
    output logic [RAD_W-1:0] o_rad   [3]
);

    localparam logic signed [Q_W-1:0] Q_BIG  = Q_W'(SCALE_SH);
    localparam logic signed [Q_W-1:0] Q_TINY = Q_W'(SCALE_SH - (1 << SH_BITS));

    logic [KC_W-1:0]        r_kc  [3];
    logic [M_W-1:0]         r_k_m [3];
    logic                   r_k_vld;
    logic                   r_k_pos;
    logic                   r_k_big;
    logic                   r_k_tiny;
    logic [SH_BITS-1:0]     r_k_sh;
    logic                   r_l_vld;
    logic [RAD_W-1:0]       r_rad [3];

    logic [M_W-1:0]         n_k_m [3];
    logic signed [Q_W-1:0]  sh_full;
    logic [M_W-1:0]         shifted [3];
    logic [RAD_W-1:0]       n_rad [3];

    always_comb begin
        sh_full = Q_BIG - i_pow.q;
        for (int i = 0; i < 3; i++) begin
            n_k_m[i]   = M_W'(r_kc[i]) * M_W'(i_pow.ptab);
            shifted[i] = r_k_m[i] >> r_k_sh;
            if (!r_k_pos || (r_k_m[i] == '0) || r_k_tiny) begin
                n_rad[i] = '0;
            end else if (r_k_big || (shifted[i] > M_W'(RAD_MAX))) begin
                n_rad[i] = RAD_MAX;
            end else begin
                n_rad[i] = shifted[i][RAD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
            r_l_vld <= 1'b0;
        end else begin
            r_k_vld <= i_pow.valid;
            r_l_vld <= r_k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_kc[i]  <= KC_W'(i_gain) * KC_W'(i_color[i]);
            r_k_m[i] <= n_k_m[i];
            r_rad[i] <= n_rad[i];
        end
        r_k_pos  <= i_pow.pos;
        r_k_big  <= i_pow.q > Q_BIG;
        r_k_tiny <= i_pow.q <= Q_TINY;
        r_k_sh   <= sh_full[SH_BITS-1:0];
    end

    assign o_valid = r_l_vld;
    assign o_rad   = r_rad;

endmodule

@@ design/phong_specular_evaluate.sv @@
// ----------------------------------------------------------------------------
// phong_specular_evaluate
// Phong specular term ks*color*(r.wo)^e with r the light reflected about n.
// ----------------------------------------------------------------------------
// Fully pipelined: one request may be started every clock cycle while o_busy
// is low, and results strobe on o_valid in request order. The depth is set by
// the three multiply rounds of the reflection and dot product, the log2/exp2
// power path and the channel scaling, each multiplier followed by a register.
// The result port has no back-pressure: o_valid lasts one cycle and the
// receiver must take it. o_busy is set during reset and clears on a clock edge
// that sees i_rst_n high; there is no clearing pass, the log2 and exp2 tables
// are constants. Configuration writes are always ready and must be issued
// while no request is in flight.
// ----------------------------------------------------------------------------
`include "phong_specular_evaluate_assert.svh"

module phong_specular_evaluate
    import phs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // request channel
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic signed [CW-1:0] i_normal_x,
    input  logic signed [CW-1:0] i_normal_y,
    input  logic signed [CW-1:0] i_normal_z,
    input  logic signed [CW-1:0] i_light_x,
    input  logic signed [CW-1:0] i_light_y,
    input  logic signed [CW-1:0] i_light_z,
    input  logic signed [CW-1:0] i_view_x,
    input  logic signed [CW-1:0] i_view_y,
    input  logic signed [CW-1:0] i_view_z,

    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    // result strobe
    output logic                 o_valid,
    output logic [RAD_W-1:0]     o_radiance_red,
    output logic [RAD_W-1:0]     o_radiance_green,
    output logic [RAD_W-1:0]     o_radiance_blue
);

    // configuration registers
    logic [CFG_W-1:0] r_gain,  n_gain;
    logic [CFG_W-1:0] r_red,   n_red;
    logic [CFG_W-1:0] r_green, n_green;
    logic [CFG_W-1:0] r_blue,  n_blue;
    logic [CFG_W-1:0] r_shine, n_shine;
    logic             r_busy;

    logic                 req_acc;
    logic                 cfg_wr;
    logic signed [CW-1:0] vec_n  [3];
    logic signed [CW-1:0] vec_wi [3];
    logic signed [CW-1:0] vec_wo [3];
    logic [CFG_W-1:0]     color  [3];
    logic [RAD_W-1:0]     rad    [3];
    t_dot                 dot;
    t_pow                 pw;

    assign req_acc     = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_busy      = r_busy;

    // register file write decode; indexes past the list are dropped
    always_comb begin
        n_gain  = r_gain;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        n_shine = r_shine;
        if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN:  n_gain  = i_cfg_data;
                CFG_RED:   n_red   = i_cfg_data;
                CFG_GREEN: n_green = i_cfg_data;
                CFG_BLUE:  n_blue  = i_cfg_data;
                CFG_SHINE: n_shine = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= '0;
            r_red   <= RAD_MAX;
            r_green <= RAD_MAX;
            r_blue  <= RAD_MAX;
            r_shine <= CFG_W'(1 << SHIN_FRAC);   // exponent 1.0
            r_busy  <= 1'b1;
        end else begin
            r_gain  <= n_gain;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_shine <= n_shine;
            r_busy  <= 1'b0;
        end
    end

    assign vec_n[0]  = i_normal_x;
    assign vec_n[1]  = i_normal_y;
    assign vec_n[2]  = i_normal_z;
    assign vec_wi[0] = i_light_x;
    assign vec_wi[1] = i_light_y;
    assign vec_wi[2] = i_light_z;
    assign vec_wo[0] = i_view_x;
    assign vec_wo[1] = i_view_y;
    assign vec_wo[2] = i_view_z;

    assign color[0] = r_red;
    assign color[1] = r_green;
    assign color[2] = r_blue;

    // stages 1-6: reflect and dot with the view direction
    phs_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_acc),
        .i_n     (vec_n),
        .i_wi    (vec_wi),
        .i_wo    (vec_wo),
        .o_dot   (dot)
    );

    // stages 7-10: d^e as 2^q * mantissa
    phs_log u_log (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dot       (dot),
        .i_shininess (r_shine),
        .o_pow       (pw)
    );

    // stages 11-12: ks*color*power, shift and saturate
    phs_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pow   (pw),
        .i_gain  (r_gain),
        .i_color (color),
        .o_valid (o_valid),
        .o_rad   (rad)
    );

    assign o_radiance_red   = rad[0];
    assign o_radiance_green = rad[1];
    assign o_radiance_blue  = rad[2];

    // every result strobe traces back to an accepted request
    `PHS_ASSERT_IMP(a_out_latency, o_valid, $past(req_acc, PIPE_LAT))
    // a non-positive r.wo comes out black
    `PHS_ASSERT_DLY(a_black_miss, pw.valid && !pw.pos, SCALE_LAT, o_valid && (o_radiance_red == '0) && (o_radiance_green == '0) && (o_radiance_blue == '0))
    // power mantissa stays in [1.0, 2.0)
    `PHS_ASSERT_IMP(a_ptab_norm, pw.valid && pw.pos, pw.ptab[PTAB_W-1])

endmodule
